// ===== src/pirl_pkg.sv =====
// Package for the positional insert/remove list: operation and status codes,
// the command that the controller broadcasts to the storage cells, and field widths.
// No dependencies; every other file of the block refers to it by scoped names.
package pirl_pkg;

  // Field widths fixed by the stream format
  localparam int POS_W   = 5;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;
  localparam int RV_W    = 32;

  typedef enum logic [1:0] {
    MODE_READ   = 2'd0,
    MODE_WRITE  = 2'd1,
    MODE_INSERT = 2'd2,
    MODE_REMOVE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_WRITE  = 2'd1,
    CELL_INSERT = 2'd2,
    CELL_REMOVE = 2'd3
  } cell_op_t;

  // Command broadcast to every cell, plus the flag that keeps the read word.
  typedef struct packed {
    cell_op_t op;
    logic     take_read;
  } cell_cmd_t;

endpackage

// ===== src/pirl_cell.sv =====
// One storage cell of the list: holds a single word and loads it from the
// input value or from a neighbouring cell. Depends on pirl_pkg.
module pirl_cell #(
  parameter int INDEX      = 0,
  parameter int DATA_WIDTH = 32,
  parameter int CMP_W      = 5
) (
  input  logic                    clk,
  input  pirl_pkg::cell_cmd_t     cmd,
  input  logic [CMP_W-1:0]        position,
  input  logic [DATA_WIDTH-1:0]   value,
  input  logic [DATA_WIDTH-1:0]   left,
  input  logic [DATA_WIDTH-1:0]   right,
  output logic [DATA_WIDTH-1:0]   data,
  output logic [DATA_WIDTH-1:0]   hit_data
);

  logic at_pos;
  logic past_pos;

  assign at_pos   = (position == CMP_W'(INDEX));
  assign past_pos = (CMP_W'(INDEX) > position);

  // The word presented for the read selection when this cell is addressed.
  assign hit_data = at_pos ? data : '0;

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      pirl_pkg::CELL_HOLD: begin
      end
      pirl_pkg::CELL_WRITE: begin
        if (at_pos) begin
          data <= value;
        end
      end
      pirl_pkg::CELL_INSERT: begin
        if (at_pos) begin
          data <= value;
        end else if (past_pos) begin
          data <= left;
        end
      end
      pirl_pkg::CELL_REMOVE: begin
        if (at_pos || past_pos) begin
          data <= right;
        end
      end
    endcase
  end

endmodule

// ===== src/pirl_ctrl.sv =====
// Controller of the list: holds the word count, checks each operation and
// issues the command to the cell row. Depends on pirl_pkg.
module pirl_ctrl #(
  parameter int CAPACITY = 16,
  parameter int LEN_W    = 5,
  parameter int CMP_W    = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  pirl_pkg::mode_t      mode,
  input  logic [CMP_W-1:0]     position,
  output pirl_pkg::cell_cmd_t  cmd,
  output pirl_pkg::status_t    status,
  output logic [LEN_W-1:0]     length_next
);

  logic [LEN_W-1:0] length;
  logic [CMP_W-1:0] len_ext;
  logic             full;

  assign len_ext = CMP_W'(length);
  assign full    = (length == LEN_W'(CAPACITY));

  always_comb begin
    cmd.op        = pirl_pkg::CELL_HOLD;
    cmd.take_read = 1'b0;
    status        = pirl_pkg::ST_OK;
    length_next   = length;
    if (mode == pirl_pkg::MODE_INSERT) begin
      if (position > len_ext) begin
        status = pirl_pkg::ST_RANGE;
      end else if (full) begin
        status = pirl_pkg::ST_FULL;
      end else begin
        cmd.op      = pirl_pkg::CELL_INSERT;
        length_next = length + LEN_W'(1);
      end
    end else if (position >= len_ext) begin
      status = pirl_pkg::ST_RANGE;
    end else begin
      unique case (mode)
        pirl_pkg::MODE_READ: begin
          cmd.take_read = 1'b1;
        end
        pirl_pkg::MODE_WRITE: begin
          cmd.op = pirl_pkg::CELL_WRITE;
        end
        pirl_pkg::MODE_REMOVE: begin
          cmd.op        = pirl_pkg::CELL_REMOVE;
          cmd.take_read = 1'b1;
          length_next   = length - LEN_W'(1);
        end
        default: begin
        end
      endcase
    end
    if (!fire) begin
      cmd.op = pirl_pkg::CELL_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
    end else if (fire) begin
      length <= length_next;
    end
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    length <= LEN_W'(CAPACITY))
    else $error("word count exceeds capacity");

  a_reject_keeps_len: assert property (@(posedge clk) disable iff (rst)
    (!rst && fire && status != pirl_pkg::ST_OK) |=> $stable(length))
    else $error("rejected operation changed the word count");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (!rst && cmd.op == pirl_pkg::CELL_INSERT) |=> (length == $past(length) + LEN_W'(1)))
    else $error("insert did not grow the list by one");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |-> (cmd.op == pirl_pkg::CELL_HOLD))
    else $error("cells commanded without an accepted transfer");
`endif

endmodule

// ===== src/positional_insert_remove_list.sv =====
// Top level of the positional insert/remove list: the controller, the row of
// storage cells and the result register. Depends on pirl_pkg, pirl_ctrl, pirl_cell.
//
// The block keeps an ordered list of up to CAPACITY words and performs one
// operation per input transfer: read, overwrite, insert (later words move up
// one place) or remove (later words move down one place, removed word is
// returned). Each input transfer yields exactly one result transfer carrying
// the word read or removed (zero otherwise), the word count after the
// operation and a status code; a rejected operation leaves the list as it was.
// Every word sits in its own cell and all cells shift together, so any
// operation completes in the cycle of its input transfer: one transfer per
// clock cycle is accepted while the output is not stalled; its result
// appears in the next cycle. The result register sits between the sides, so
// a new input transfer is taken in the same cycle as the waiting result is.
module positional_insert_remove_list #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // position [4:0], value [36:5], zeros above
  input  logic [1:0]  s_tuser,   // mode [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // read_value [31:0], count [36:32], zeros above
  output logic [1:0]  m_tuser    // status [1:0]
);

  localparam int LEN_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (LEN_W > pirl_pkg::POS_W) ? LEN_W : pirl_pkg::POS_W;

  logic                          fire;
  logic [pirl_pkg::POS_W-1:0]    position;
  logic [pirl_pkg::VALUE_W-1:0]  value_bits;
  logic [CMP_W-1:0]              pos_ext;
  logic [DATA_WIDTH-1:0]         store_value;
  pirl_pkg::mode_t               mode;
  pirl_pkg::cell_cmd_t           cmd;
  pirl_pkg::status_t             status;
  logic [LEN_W-1:0]              length_next;

  logic [DATA_WIDTH-1:0]         cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0]         hit_data  [CAPACITY];
  logic [DATA_WIDTH-1:0]         sel_data;

  // Result register
  logic                          out_valid;
  logic [pirl_pkg::RV_W-1:0]     read_value;
  logic [pirl_pkg::COUNT_W-1:0]  count;
  pirl_pkg::status_t             out_status;

  assign s_tready   = !rst && (!out_valid || m_tready);
  assign fire       = s_tvalid && s_tready;
  assign mode       = pirl_pkg::mode_t'(s_tuser);
  assign position   = s_tdata[4:0];
  assign value_bits = s_tdata[36:5];
  assign pos_ext    = CMP_W'(position);
  // Only the low DATA_WIDTH bits of the word are kept (zero-extended if wider).
  assign store_value = DATA_WIDTH'(value_bits);

  pirl_ctrl #(
    .CAPACITY (CAPACITY),
    .LEN_W    (LEN_W),
    .CMP_W    (CMP_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .mode        (mode),
    .position    (pos_ext),
    .cmd         (cmd),
    .status      (status),
    .length_next (length_next)
  );

  // The row of cells. Each cell sees its left and right neighbour; the ends
  // feed back their own word: unused at cell 0, kept by the last on a remove.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left;
    logic [DATA_WIDTH-1:0] right;

    if (i == 0) begin : g_first
      assign left = cell_data[i];
    end else begin : g_inner_left
      assign left = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_inner_right
      assign right = cell_data[i+1];
    end

    pirl_cell #(
      .INDEX      (i),
      .DATA_WIDTH (DATA_WIDTH),
      .CMP_W      (CMP_W)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .position (pos_ext),
      .value    (store_value),
      .left     (left),
      .right    (right),
      .data     (cell_data[i]),
      .hit_data (hit_data[i])
    );
  end

  // Only the addressed cell drives a non-zero word, so an OR picks it out.
  always_comb begin
    sel_data = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      sel_data = sel_data | hit_data[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      read_value <= cmd.take_read ? pirl_pkg::RV_W'(sel_data) : '0;
      count      <= pirl_pkg::COUNT_W'(length_next);
      out_status <= status;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, count, read_value};
  assign m_tuser  = out_status;

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> s_tready)
    else $error("input stalled with an empty result register");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (!rst && fire) |=> m_tvalid)
    else $error("accepted transfer produced no result");

  a_reject_no_word: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status != pirl_pkg::ST_OK) |-> (read_value == '0))
    else $error("rejected operation returned a word");
`endif

endmodule
